// File: hdl/jd2g_pkg.sv
// ============================================================================
// jd2g_pkg: shared constants and types for the Julian date converter
// Field widths, calendar constants, reciprocal multipliers for the constant
// divisions, and the pipeline control bundle.
// ============================================================================
package jd2g_pkg;

    // Field widths.
    localparam int DAY_NUM_W  = 23;
    localparam int DAY_FRAC_W = 32;
    localparam int YEAR_W     = 16;
    localparam int MONTH_W    = 4;
    localparam int DOM_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;

    // Number of register stages in the datapath.
    localparam int NUM_STAGES = 9;

    // Time constants. 86400 = 675 * 2^7, so the seconds product is split.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [9:0]  SEC_MUL      = 10'd675;
    localparam logic [11:0] SECS_PER_HR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;

    // Calendar constants of the integer Julian-day-to-Gregorian formula.
    localparam logic [18:0] GREG_B      = 19'd274277;
    localparam logic [10:0] GREG_J      = 11'd1401;
    localparam logic [5:0]  GREG_C      = 6'd38;
    localparam logic [10:0] GREG_P      = 11'd1461;
    localparam logic [7:0]  GREG_S      = 8'd153;
    localparam logic [12:0] YEAR_OFFSET = 13'd4716;
    localparam logic [3:0]  MONTHS      = 4'd12;

    // Rounded-up reciprocals: floor(x / D) == (x * M) >> K whenever
    // x_max * D < 2^K, with M = ceil(2^K / D).
    localparam logic [20:0] HOUR_MUL  = 21'(((64'd1 << 32) + 64'd3599) / 64'd3600);
    localparam logic [14:0] MIN_MUL   = 15'(((64'd1 << 20) + 64'd59) / 64'd60);
    localparam logic [26:0] CYCLE_MUL = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
    localparam logic [25:0] QUAD_MUL  = 26'(((64'd1 << 36) + 64'd1460) / 64'd1461);
    localparam logic [12:0] MSPAN_MUL = 13'(((64'd1 << 20) + 64'd152) / 64'd153);
    localparam logic [9:0]  FIVE_MUL  = 10'(((64'd1 << 12) + 64'd4) / 64'd5);

    // Per-stage load enables and valid flags from the pipeline controller.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } jd2g_pipe_t;

endpackage

// File: hdl/jd2g_pipe_ctl.sv
// ============================================================================
// jd2g_pipe_ctl: valid/ready control for the converter pipeline
// Each stage takes new data when it is empty or its successor takes its
// content, so bubbles close up; a stall holds a stage once all ahead are full.
// ============================================================================
module jd2g_pipe_ctl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  out_ready,
    output logic                  in_ready,
    output jd2g_pkg::jd2g_pipe_t  pipe
);
    import jd2g_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;
    logic [NUM_STAGES-1:0] stage_in;

    always_comb begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        stage_in = {valid_reg[NUM_STAGES-2:0], in_valid};
        for (int i = 0; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_ready[i] ? stage_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = stage_ready[0];
    assign pipe.load  = stage_in & stage_ready[NUM_STAGES-1:0];
    assign pipe.valid = valid_reg;

endmodule

// File: hdl/julian_date_to_gregorian.sv
// ============================================================================
// julian_date_to_gregorian: Julian date to Gregorian date and time of day
// Nine-stage pipeline converting a day number and day fraction to a
// proleptic Gregorian calendar date and a time rounded to the second.
// ============================================================================
// Usage:
// The input channel (s_valid/s_ready) carries one Julian date per transfer:
// a whole day number and a 0.32 fixed-point fraction of a day counted from
// noon. The result channel (m_valid/m_ready) carries one calendar date and
// time per input transfer, in input order. The astronomical year counts
// year 0 as 1 BC.
// An input transfer passes through the nine register stages to m_valid;
// a new transfer is accepted every cycle while s_ready is high, so the
// throughput is one item per cycle when the receiver does not stall.
// When the receiver holds m_ready low, the output stage keeps its result and
// the stages behind it keep filling until every stage holds an item; then
// s_ready drops. Nothing is lost or repeated across a stall.
// The synchronous active-low reset empties all stages; data registers keep
// whatever they hold, since only the valid flags matter.
// ============================================================================
module julian_date_to_gregorian (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [jd2g_pkg::DAY_NUM_W-1:0]   s_day_number,
    input  logic [jd2g_pkg::DAY_FRAC_W-1:0]  s_day_fraction,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [jd2g_pkg::YEAR_W-1:0] m_year,
    output logic [jd2g_pkg::MONTH_W-1:0]     m_month,
    output logic [jd2g_pkg::DOM_W-1:0]       m_day_of_month,
    output logic [jd2g_pkg::HOUR_W-1:0]      m_hour,
    output logic [jd2g_pkg::MINUTE_W-1:0]    m_minute,
    output logic [jd2g_pkg::SECOND_W-1:0]    m_second
);
    import jd2g_pkg::*;

    jd2g_pipe_t pipe;

    jd2g_pipe_ctl u_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .out_ready (m_ready),
        .in_ready  (s_ready),
        .pipe      (pipe)
    );

    assign m_valid = pipe.valid[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: the time since midnight is the fraction plus half a day.
    // Multiply by 675 here; the remaining factor 2^7 folds into the shift.
    // ------------------------------------------------------------------
    logic [32:0] midnight_time;
    logic [42:0] tprod1_reg;
    logic [22:0] jdn1_reg;

    assign midnight_time = {1'b0, s_day_fraction} + 33'h0_8000_0000;

    always_ff @(posedge aclk) begin
        if (pipe.load[0]) begin
            tprod1_reg <= 43'(midnight_time) * 43'(SEC_MUL);
            jdn1_reg   <= s_day_number;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round to the nearest second, then carry a full day into
    // the day number. The rounded count lies between 43200 and 129600.
    // ------------------------------------------------------------------
    logic [42:0] tround;
    logic [16:0] secs_raw;
    logic        day_carry;
    logic [16:0] secs2_reg;
    logic [23:0] jdn2_reg;

    assign tround    = tprod1_reg + 43'h000_0100_0000;
    assign secs_raw  = tround[41:25];
    assign day_carry = (secs_raw >= SECS_PER_DAY);

    always_ff @(posedge aclk) begin
        if (pipe.load[1]) begin
            secs2_reg <= day_carry ? (secs_raw - SECS_PER_DAY) : secs_raw;
            jdn2_reg  <= {1'b0, jdn1_reg} + 24'(day_carry);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: reciprocal products for the hour and for the 400-year
    // cycle count (4 * jdn + 274277) / 146097.
    // ------------------------------------------------------------------
    logic [25:0] cycle_arg;
    logic [37:0] hprod3_reg;
    logic [52:0] aprod3_reg;
    logic [16:0] secs3_reg;
    logic [23:0] jdn3_reg;

    assign cycle_arg = {jdn2_reg, 2'b00} + 26'(GREG_B);

    always_ff @(posedge aclk) begin
        if (pipe.load[2]) begin
            hprod3_reg <= 38'(secs2_reg) * 38'(HOUR_MUL);
            aprod3_reg <= 53'(cycle_arg) * 53'(CYCLE_MUL);
            secs3_reg  <= secs2_reg;
            jdn3_reg   <= jdn2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: hour and the seconds left in the hour; the Gregorian
    // correction gives f, and e = 4 * f + 3.
    // ------------------------------------------------------------------
    logic [HOUR_W-1:0] hour_q;
    logic [7:0]        cycles_q;
    logic [9:0]        cycles_x3;
    logic [23:0]       greg_f;
    logic [HOUR_W-1:0] hour4_reg;
    logic [11:0]       remh4_reg;
    logic [25:0]       e4_reg;

    assign hour_q    = hprod3_reg[36:32];
    assign cycles_q  = aprod3_reg[51:44];
    assign cycles_x3 = 10'(cycles_q) * 10'd3;
    assign greg_f    = jdn3_reg + 24'(GREG_J) - 24'(GREG_C) + 24'(cycles_x3[9:2]);

    always_ff @(posedge aclk) begin
        if (pipe.load[3]) begin
            hour4_reg <= hour_q;
            remh4_reg <= 12'(secs3_reg - 17'(hour_q) * 17'(SECS_PER_HR));
            e4_reg    <= {greg_f, 2'b11};
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: reciprocal products for the minute and for e / 1461.
    // ------------------------------------------------------------------
    logic [HOUR_W-1:0] hour5_reg;
    logic [11:0]       remh5_reg;
    logic [26:0]       mprod5_reg;
    logic [25:0]       e5_reg;
    logic [51:0]       eprod5_reg;

    always_ff @(posedge aclk) begin
        if (pipe.load[4]) begin
            hour5_reg  <= hour4_reg;
            remh5_reg  <= remh4_reg;
            mprod5_reg <= 27'(remh4_reg) * 27'(MIN_MUL);
            e5_reg     <= e4_reg;
            eprod5_reg <= 52'(e4_reg) * 52'(QUAD_MUL);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: minute and second; the day within the four-year span gives
    // g, and h = 5 * g + 2.
    // ------------------------------------------------------------------
    logic [MINUTE_W-1:0] minute_q;
    logic [14:0]         quad_q;
    logic [10:0]         quad_rem;
    logic [HOUR_W-1:0]   hour6_reg;
    logic [MINUTE_W-1:0] minute6_reg;
    logic [SECOND_W-1:0] second6_reg;
    logic [14:0]         quad6_reg;
    logic [10:0]         h6_reg;

    assign minute_q = mprod5_reg[25:20];
    assign quad_q   = eprod5_reg[50:36];
    assign quad_rem = 11'(e5_reg - 26'(quad_q) * 26'(GREG_P));

    always_ff @(posedge aclk) begin
        if (pipe.load[5]) begin
            hour6_reg   <= hour5_reg;
            minute6_reg <= minute_q;
            second6_reg <= 6'(remh5_reg - 12'(minute_q) * 12'(SECS_PER_MIN));
            quad6_reg   <= quad_q;
            h6_reg      <= 11'(quad_rem[10:2]) * 11'd5 + 11'd2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: reciprocal product for h / 153.
    // ------------------------------------------------------------------
    logic [HOUR_W-1:0]   hour7_reg;
    logic [MINUTE_W-1:0] minute7_reg;
    logic [SECOND_W-1:0] second7_reg;
    logic [14:0]         quad7_reg;
    logic [10:0]         h7_reg;
    logic [23:0]         sprod7_reg;

    always_ff @(posedge aclk) begin
        if (pipe.load[6]) begin
            hour7_reg   <= hour6_reg;
            minute7_reg <= minute6_reg;
            second7_reg <= second6_reg;
            quad7_reg   <= quad6_reg;
            h7_reg      <= h6_reg;
            sprod7_reg  <= 24'(h6_reg) * 24'(MSPAN_MUL);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: month from the March-based month index, and the year.
    // January and February belong to the following year.
    // ------------------------------------------------------------------
    logic [3:0]          mspan_q;
    logic [3:0]          month_raw;
    logic [MONTH_W-1:0]  month_q;
    logic [14:0]         year_q;
    logic [HOUR_W-1:0]   hour8_reg;
    logic [MINUTE_W-1:0] minute8_reg;
    logic [SECOND_W-1:0] second8_reg;
    logic [7:0]          hd8_reg;
    logic [MONTH_W-1:0]  month8_reg;
    logic signed [YEAR_W-1:0] year8_reg;

    assign mspan_q   = sprod7_reg[23:20];
    assign month_raw = mspan_q + 4'd2;
    assign month_q   = ((month_raw >= MONTHS) ? (month_raw - MONTHS) : month_raw) + 4'd1;
    assign year_q    = quad7_reg + 15'(month_q <= 4'd2);

    always_ff @(posedge aclk) begin
        if (pipe.load[7]) begin
            hour8_reg   <= hour7_reg;
            minute8_reg <= minute7_reg;
            second8_reg <= second7_reg;
            hd8_reg     <= 8'(h7_reg - 11'(mspan_q) * 11'(GREG_S));
            month8_reg  <= month_q;
            year8_reg   <= $signed({1'b0, year_q}) - $signed(16'(YEAR_OFFSET));
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: day of month = hd / 5 + 1, and the output register.
    // ------------------------------------------------------------------
    logic [17:0]         dprod;
    logic signed [YEAR_W-1:0] year9_reg;
    logic [MONTH_W-1:0]  month9_reg;
    logic [DOM_W-1:0]    dom9_reg;
    logic [HOUR_W-1:0]   hour9_reg;
    logic [MINUTE_W-1:0] minute9_reg;
    logic [SECOND_W-1:0] second9_reg;

    assign dprod = 18'(hd8_reg) * 18'(FIVE_MUL);

    always_ff @(posedge aclk) begin
        if (pipe.load[8]) begin
            year9_reg   <= year8_reg;
            month9_reg  <= month8_reg;
            dom9_reg    <= dprod[16:12] + 5'd1;
            hour9_reg   <= hour8_reg;
            minute9_reg <= minute8_reg;
            second9_reg <= second8_reg;
        end
    end

    assign m_year         = year9_reg;
    assign m_month        = month9_reg;
    assign m_day_of_month = dom9_reg;
    assign m_hour         = hour9_reg;
    assign m_minute       = minute9_reg;
    assign m_second       = second9_reg;

endmodule

// File: hdl/jd2g_chk.sv
// ============================================================================
// jd2g_chk: port-level checks for the Julian date converter
// Watches the top-level ports for reset behavior, stall behavior and
// result ranges; bound to every instance of the top level.
// ============================================================================
module jd2g_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [jd2g_pkg::DAY_NUM_W-1:0]    s_day_number,
    input logic [jd2g_pkg::DAY_FRAC_W-1:0]   s_day_fraction,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [jd2g_pkg::YEAR_W-1:0] m_year,
    input logic [jd2g_pkg::MONTH_W-1:0]      m_month,
    input logic [jd2g_pkg::DOM_W-1:0]        m_day_of_month,
    input logic [jd2g_pkg::HOUR_W-1:0]       m_hour,
    input logic [jd2g_pkg::MINUTE_W-1:0]     m_minute,
    input logic [jd2g_pkg::SECOND_W-1:0]     m_second
);

    // Reset empties the pipeline, so no result shows in the next cycle.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result stays put until the receiver takes it.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_year) && $stable(m_month)
            && $stable(m_day_of_month) && $stable(m_hour)
            && $stable(m_minute) && $stable(m_second))
        else $error("stalled result changed or dropped");

    // Date fields stay in range: month 1 to 12, day from 1, year from -4713.
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_month >= 4'd1 && m_month <= 4'd12
            && m_day_of_month >= 5'd1 && m_year >= -16'sd4713)
        else $error("date field out of range");

    // Time of day never reaches a carry value.
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59)
        else $error("time field out of range");

    // With the output stalled and the input held off, the pipeline is full,
    // so the output stage keeps a valid result.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input blocked while output is free");

endmodule

bind julian_date_to_gregorian jd2g_chk u_jd2g_chk (.*);
